// ----- hdl/usbep_pkg.sv -----
// ----------------------------------------------------------------------------
// usbep_pkg
// Types and constants shared by the endpoint zero responder and its output
// queue: request and response structs, response kinds, request codes.
// ----------------------------------------------------------------------------
package usbep_pkg;

    // One input request: a setup packet or an IN-complete event
    typedef struct packed {
        logic        action;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_req;

    // Response kinds
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_ZLP       = 2'd1,
        KIND_SET_ADDR  = 2'd2,
        KIND_EP_ENABLE = 2'd3
    } t_kind;

    // One response item
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  descriptor_id;
        logic [9:0]  byte_offset;
        logic [6:0]  packet_length;
        logic [6:0]  device_address;
        logic        endpoints_on;
        logic        last;
    } t_rsp;

    // Action codes of the input request
    localparam logic ACT_SETUP       = 1'b0;
    localparam logic ACT_IN_COMPLETE = 1'b1;

    // bmRequestType class field
    localparam logic [1:0] CLASS_STANDARD = 2'd0;
    localparam logic [1:0] CLASS_CLASS    = 2'd1;

    // bRequest codes
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_SET_IDLE          = 8'd10;

    // Descriptor types (high byte of wValue)
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;

    // String descriptor indexes
    localparam logic [7:0] STR_LANGID  = 8'd0;
    localparam logic [7:0] STR_MAKER   = 8'd1;
    localparam logic [7:0] STR_PRODUCT = 8'd2;
    localparam logic [7:0] STR_SERIAL  = 8'd3;

    // Descriptor ids reported on the response
    localparam logic [2:0] DESC_DEVICE  = 3'd0;
    localparam logic [2:0] DESC_CONFIG  = 3'd1;
    localparam logic [2:0] DESC_LANGID  = 3'd2;
    localparam logic [2:0] DESC_MAKER   = 3'd3;
    localparam logic [2:0] DESC_PRODUCT = 3'd4;
    localparam logic [2:0] DESC_SERIAL  = 3'd5;
    localparam logic [2:0] DESC_REPORT  = 3'd6;

    // Fixed descriptor lengths in bytes
    localparam logic [9:0] LEN_MAKER   = 10'd18;
    localparam logic [9:0] LEN_PRODUCT = 10'd44;
    localparam logic [9:0] LEN_SERIAL  = 10'd22;
    localparam logic [9:0] LEN_REPORT  = 10'd45;

    // Packet size shift limits
    localparam logic [2:0] SHIFT_MIN = 3'd3;
    localparam logic [2:0] SHIFT_MAX = 3'd6;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] CFG_MAX_PACKET_SHIFT    = 2'd0;
    localparam logic [1:0] CFG_DEVICE_DESC_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_CONFIG_TOTAL_LENGTH = 2'd2;
    localparam logic [1:0] CFG_LANGID_LENGTH       = 2'd3;

    // Configuration reset values
    localparam logic [2:0] RST_MAX_PACKET_SHIFT    = 3'd4;
    localparam logic [7:0] RST_DEVICE_DESC_LENGTH  = 8'd18;
    localparam logic [9:0] RST_CONFIG_TOTAL_LENGTH = 10'd41;
    localparam logic [7:0] RST_LANGID_LENGTH       = 8'd4;

endpackage

// ----- hdl/usb_control_endpoint_responder.sv -----
// Path: input register, then the response queue that drives o_valid; a request
//   waits in the input register while the queue lacks room for two responses.
// Throughput: one request per cycle while the queue has room; SET_ADDRESS and
//   SET_CONFIGURATION give two; the output port, one response per cycle, rules.
// Reset: synchronous, active low; clears transfer state, the response queue
//   and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// Endpoint zero control request decoder: descriptor chunking, zero-length
// packet handling and address/configuration actions, with an APB register port.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder
    import usbep_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    // response channel
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [2:0]  r_max_packet_shift;
    logic [7:0]  r_device_desc_length;
    logic [9:0]  r_config_total_length;
    logic [7:0]  r_langid_length;

    // transfer state
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [9:0]  r_send_offset, n_send_offset;
    logic [2:0]  r_sel_desc, n_sel_desc;
    logic        r_zlp_pending, n_zlp_pending;
    logic [7:0]  r_config_value;

    // input register
    logic        r_in_valid;
    t_req        r_in;

    logic        w_fire;
    logic        w_room;
    logic        w_cfg_wr;

    // decode
    logic [1:0]  w_cls;
    logic [7:0]  w_dtype;
    logic [7:0]  w_dindex;
    logic        w_desc_hit;
    logic [2:0]  w_desc_id;
    logic [9:0]  w_desc_full;
    logic        w_is_get, w_is_addr, w_is_cfg, w_is_idle, w_run;
    logic [2:0]  w_shift;
    logic [6:0]  w_pkt;
    logic [6:0]  w_pkt_mask;

    // chunk engine
    logic [15:0] w_pre_bl;
    logic [9:0]  w_pre_off;
    logic [2:0]  w_pre_sel;
    logic        w_pre_zlp;
    logic        w_chunk_valid;
    t_rsp        w_chunk;
    t_rsp        w_action;
    t_rsp        w_res0, w_res1;
    logic [1:0]  w_push_n;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_shift    <= RST_MAX_PACKET_SHIFT;
            r_device_desc_length  <= RST_DEVICE_DESC_LENGTH;
            r_config_total_length <= RST_CONFIG_TOTAL_LENGTH;
            r_langid_length       <= RST_LANGID_LENGTH;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                CFG_MAX_PACKET_SHIFT:    r_max_packet_shift    <= pwdata[2:0];
                CFG_DEVICE_DESC_LENGTH:  r_device_desc_length  <= pwdata[7:0];
                CFG_CONFIG_TOTAL_LENGTH: r_config_total_length <= pwdata[9:0];
                CFG_LANGID_LENGTH:       r_langid_length       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            CFG_MAX_PACKET_SHIFT:    prdata = {29'd0, r_max_packet_shift};
            CFG_DEVICE_DESC_LENGTH:  prdata = {24'd0, r_device_desc_length};
            CFG_CONFIG_TOTAL_LENGTH: prdata = {22'd0, r_config_total_length};
            CFG_LANGID_LENGTH:       prdata = {24'd0, r_langid_length};
            default:                 prdata = '0;
        endcase
    end

    // input register: refills while the held request moves on
    assign w_fire  = r_in_valid && w_room;
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_req;
        end
    end

    // packet size, clamped to 8..64 bytes
    always_comb begin
        if (r_max_packet_shift < SHIFT_MIN) begin
            w_shift = SHIFT_MIN;
        end else if (r_max_packet_shift > SHIFT_MAX) begin
            w_shift = SHIFT_MAX;
        end else begin
            w_shift = r_max_packet_shift;
        end
    end
    assign w_pkt      = 7'd1 << w_shift;
    assign w_pkt_mask = w_pkt - 7'd1;

    // descriptor lookup
    assign w_dtype  = r_in.request_value[15:8];
    assign w_dindex = r_in.request_value[7:0];

    always_comb begin
        w_desc_hit  = 1'b1;
        w_desc_id   = DESC_DEVICE;
        w_desc_full = {2'd0, r_device_desc_length};
        unique case (w_dtype)
            DT_DEVICE: begin
                w_desc_id   = DESC_DEVICE;
                w_desc_full = {2'd0, r_device_desc_length};
            end
            DT_CONFIG: begin
                w_desc_id   = DESC_CONFIG;
                w_desc_full = r_config_total_length;
            end
            DT_REPORT: begin
                w_desc_id   = DESC_REPORT;
                w_desc_full = LEN_REPORT;
            end
            DT_STRING: begin
                unique case (w_dindex)
                    STR_LANGID: begin
                        w_desc_id   = DESC_LANGID;
                        w_desc_full = {2'd0, r_langid_length};
                    end
                    STR_MAKER: begin
                        w_desc_id   = DESC_MAKER;
                        w_desc_full = LEN_MAKER;
                    end
                    STR_PRODUCT: begin
                        w_desc_id   = DESC_PRODUCT;
                        w_desc_full = LEN_PRODUCT;
                    end
                    STR_SERIAL: begin
                        w_desc_id   = DESC_SERIAL;
                        w_desc_full = LEN_SERIAL;
                    end
                    default: w_desc_hit = 1'b0;
                endcase
            end
            default: w_desc_hit = 1'b0;
        endcase
    end

    // request decode
    assign w_cls     = r_in.request_type[6:5];
    assign w_is_get  = (r_in.action == ACT_SETUP) && r_in.request_type[7]
                       && (w_cls == CLASS_STANDARD)
                       && (r_in.request_code == REQ_GET_DESCRIPTOR) && w_desc_hit;
    assign w_is_addr = (r_in.action == ACT_SETUP) && !r_in.request_type[7]
                       && (w_cls == CLASS_STANDARD)
                       && (r_in.request_code == REQ_SET_ADDRESS);
    assign w_is_cfg  = (r_in.action == ACT_SETUP) && !r_in.request_type[7]
                       && (w_cls == CLASS_STANDARD)
                       && (r_in.request_code == REQ_SET_CONFIGURATION);
    assign w_is_idle = (r_in.action == ACT_SETUP) && !r_in.request_type[7]
                       && (w_cls == CLASS_CLASS)
                       && (r_in.request_code == REQ_SET_IDLE);
    assign w_run     = (r_in.action == ACT_IN_COMPLETE) || w_is_get || w_is_addr
                       || w_is_cfg || w_is_idle;

    // transfer state as set up by the request, before the chunk is taken
    always_comb begin
        w_pre_bl  = r_bytes_left;
        w_pre_off = r_send_offset;
        w_pre_sel = r_sel_desc;
        w_pre_zlp = r_zlp_pending;
        if (w_is_get) begin
            w_pre_sel = w_desc_id;
            w_pre_off = '0;
            if (r_in.request_length > {6'd0, w_desc_full}) begin
                w_pre_bl  = {6'd0, w_desc_full};
                w_pre_zlp = ((w_desc_full & {3'd0, w_pkt_mask}) == 10'd0);
            end else begin
                w_pre_bl  = r_in.request_length;
                w_pre_zlp = 1'b0;
            end
        end else if (w_is_addr || w_is_cfg || w_is_idle) begin
            w_pre_bl  = '0;
            w_pre_zlp = 1'b1;
        end
    end

    // next chunk: full packet, short packet, zero-length packet or nothing
    always_comb begin
        n_bytes_left  = w_pre_bl;
        n_send_offset = w_pre_off;
        n_sel_desc    = w_pre_sel;
        n_zlp_pending = w_pre_zlp;
        w_chunk       = '0;
        w_chunk_valid = 1'b0;
        if (w_pre_bl > {9'd0, w_pkt}) begin
            w_chunk_valid         = 1'b1;
            w_chunk.kind          = KIND_DATA;
            w_chunk.descriptor_id = w_pre_sel;
            w_chunk.byte_offset   = w_pre_off;
            w_chunk.packet_length = w_pkt;
            n_bytes_left          = w_pre_bl - {9'd0, w_pkt};
            n_send_offset         = w_pre_off + {3'd0, w_pkt};
        end else if (w_pre_bl != 16'd0) begin
            w_chunk_valid         = 1'b1;
            w_chunk.kind          = KIND_DATA;
            w_chunk.descriptor_id = w_pre_sel;
            w_chunk.byte_offset   = w_pre_off;
            w_chunk.packet_length = w_pre_bl[6:0];
            n_bytes_left          = '0;
            n_send_offset         = w_pre_off + {3'd0, w_pre_bl[6:0]};
        end else if (w_pre_zlp) begin
            w_chunk_valid = 1'b1;
            w_chunk.kind  = KIND_ZLP;
            n_zlp_pending = 1'b0;
        end
    end

    // action response for set address / set configuration
    always_comb begin
        w_action = '0;
        if (w_is_addr) begin
            w_action.kind           = KIND_SET_ADDR;
            w_action.device_address = r_in.request_value[6:0];
        end else begin
            w_action.kind         = KIND_EP_ENABLE;
            w_action.endpoints_on = (r_in.request_value[7:0] != 8'd0);
        end
    end

    // response assembly, last flag on the final one
    always_comb begin
        w_res0   = w_chunk;
        w_res1   = w_chunk;
        w_push_n = 2'd0;
        if (w_is_addr || w_is_cfg) begin
            w_res0      = w_action;
            w_res1.last = 1'b1;
            w_push_n    = 2'd2;
        end else if (w_run && w_chunk_valid) begin
            w_res0.last = 1'b1;
            w_push_n    = 2'd1;
        end
        if (!w_fire) begin
            w_push_n = 2'd0;
        end
    end

    // transfer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left   <= '0;
            r_send_offset  <= '0;
            r_sel_desc     <= DESC_DEVICE;
            r_zlp_pending  <= 1'b0;
            r_config_value <= '0;
        end else if (w_fire && w_run) begin
            r_bytes_left  <= n_bytes_left;
            r_send_offset <= n_send_offset;
            r_sel_desc    <= n_sel_desc;
            r_zlp_pending <= n_zlp_pending;
            if (w_is_cfg) begin
                r_config_value <= r_in.request_value[7:0];
            end
        end
    end

    usbep_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_push0  (w_res0),
        .i_push1  (w_res1),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_rsp    (o_rsp)
    );

    a_status_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_is_addr || w_is_cfg)) |->
            (w_res1.kind == KIND_ZLP) && w_res1.last && !w_res0.last)
        else $error("action not followed by zero-length status packet");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n != 2'd0 && w_res0.kind == KIND_DATA) |->
            (w_res0.packet_length != 7'd0) && (w_res0.packet_length <= w_pkt))
        else $error("data packet length out of range");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_is_addr || w_is_cfg || w_is_idle)) |=>
            (r_bytes_left == 16'd0) && !r_zlp_pending)
        else $error("transfer state not cleared after status request");

    a_cfg_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_cfg) |=>
            ((r_config_value != 8'd0) == $past(w_action.endpoints_on)))
        else $error("endpoint enable disagrees with stored configuration");

endmodule

// ----- hdl/usbep_out_fifo.sv -----
// ----------------------------------------------------------------------------
// usbep_out_fifo
// Small response queue. Takes zero, one or two responses per cycle and
// presents them one at a time on a valid/ready output.
// ----------------------------------------------------------------------------
module usbep_out_fifo
    import usbep_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_rsp       i_push0,
    input  t_rsp       i_push1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rsp          r_mem [DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] w_tail_p1;
    logic          w_pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_tail_p1 = f_inc(r_tail);
    assign w_pop     = o_valid && i_ready;
    assign o_valid   = (r_count != '0);
    assign o_rsp     = r_mem[r_head];
    // room for a full two-response burst
    assign o_room    = (r_count <= CW'(DEPTH - 2));

    // pointer and count update
    always_comb begin
        n_head  = w_pop ? f_inc(r_head) : r_head;
        case (i_push_n)
            2'd1:    n_tail = w_tail_p1;
            2'd2:    n_tail = f_inc(w_tail_p1);
            default: n_tail = r_tail;
        endcase
        n_count = CW'(r_count + CW'(i_push_n) - CW'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_tail] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_tail_p1] <= i_push1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("response queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd2) |-> (r_count <= CW'(DEPTH - 2)))
        else $error("two-response push without room");

    a_push_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd3)
        else $error("illegal push count");

    a_empty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && i_push_n != 2'd0) |=> o_valid)
        else $error("pushed response not presented");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the endpoint zero responder. Requests are queued by
// a stimulus process and driven with random gaps. An in-bench model of the
// descriptor chunking and status stages predicts every response at request
// acceptance; a monitor compares responses in order, field by field. The run
// steps through several register settings written over the APB port.
// ----------------------------------------------------------------------------
module testbench;
    import usbep_pkg::*;

    localparam int          SETTLE_CYCLES  = 4;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int unsigned REQS_PER_PHASE = 100;
    localparam int          NUM_PHASES     = 8;

    // bmRequestType direction bit
    localparam logic DIR_OUT = 1'b0;
    localparam logic DIR_IN  = 1'b1;

    // Codes the block does not support
    localparam logic [7:0] DT_UNKNOWN  = 8'h07;
    localparam logic [7:0] STR_UNKNOWN = 8'd4;
    localparam logic [7:0] REQ_UNKNOWN = 8'hFF;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_req        i_req   = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_rsp        o_rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    usb_control_endpoint_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bench-side copy of the registers
    logic [2:0]  cfg_shift      = RST_MAX_PACKET_SHIFT;
    logic [7:0]  cfg_device_len = RST_DEVICE_DESC_LENGTH;
    logic [9:0]  cfg_config_len = RST_CONFIG_TOTAL_LENGTH;
    logic [7:0]  cfg_langid_len = RST_LANGID_LENGTH;

    // Bench-side copy of the transfer state
    logic [15:0] bytes_left   = '0;
    logic [9:0]  send_offset  = '0;
    logic [2:0]  cur_desc     = '0;
    logic        zlp_armed    = 1'b0;
    logic [7:0]  config_value = '0;

    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    int          errors    = 0;
    bit          idle_on   = 1'b1;
    bit          req_fire  = 1'b0;
    int unsigned req_gap   = 0;
    int unsigned rsp_stall = 0;

    // ------------------------------------------------------------------
    // Response prediction
    // ------------------------------------------------------------------
    function automatic int unsigned packet_bytes();
        logic [2:0] s;
        s = cfg_shift;
        if (s < SHIFT_MIN) s = SHIFT_MIN;
        if (s > SHIFT_MAX) s = SHIFT_MAX;
        return 1 << s;
    endfunction

    function automatic t_rsp make_rsp(t_kind kind, logic [2:0] id, logic [9:0] off,
                                      logic [6:0] len, logic [6:0] addr, logic en);
        t_rsp r;
        r.kind           = kind;
        r.descriptor_id  = id;
        r.byte_offset    = off;
        r.packet_length  = len;
        r.device_address = addr;
        r.endpoints_on   = en;
        r.last           = 1'b0;
        return r;
    endfunction

    // Next IN packet of the current transfer, or the armed zero-length packet
    function automatic bit next_chunk(output t_rsp r);
        int unsigned psize;
        psize = packet_bytes();
        r = make_rsp(KIND_ZLP, '0, '0, '0, '0, 1'b0);
        if (bytes_left > psize) begin
            r = make_rsp(KIND_DATA, cur_desc, send_offset, 7'(psize), '0, 1'b0);
            bytes_left  = bytes_left - 16'(psize);
            send_offset = send_offset + 10'(psize);
            return 1'b1;
        end
        if (bytes_left != 0) begin
            r = make_rsp(KIND_DATA, cur_desc, send_offset, 7'(bytes_left), '0, 1'b0);
            send_offset = send_offset + bytes_left[9:0];
            bytes_left  = '0;
            return 1'b1;
        end
        if (zlp_armed) begin
            zlp_armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Start a descriptor transfer; 0 when type or string index is unknown
    function automatic bit open_descriptor(logic [15:0] value, logic [15:0] wlen);
        logic [2:0] id;
        logic [9:0] full;
        case (value[15:8])
            DT_DEVICE: begin
                id   = DESC_DEVICE;
                full = 10'(cfg_device_len);
            end
            DT_CONFIG: begin
                id   = DESC_CONFIG;
                full = cfg_config_len;
            end
            DT_REPORT: begin
                id   = DESC_REPORT;
                full = LEN_REPORT;
            end
            DT_STRING: begin
                case (value[7:0])
                    STR_LANGID: begin
                        id   = DESC_LANGID;
                        full = 10'(cfg_langid_len);
                    end
                    STR_MAKER: begin
                        id   = DESC_MAKER;
                        full = LEN_MAKER;
                    end
                    STR_PRODUCT: begin
                        id   = DESC_PRODUCT;
                        full = LEN_PRODUCT;
                    end
                    STR_SERIAL: begin
                        id   = DESC_SERIAL;
                        full = LEN_SERIAL;
                    end
                    default: return 1'b0;
                endcase
            end
            default: return 1'b0;
        endcase
        cur_desc    = id;
        send_offset = '0;
        // zero-length packet only when the whole descriptor goes out
        if (wlen > 16'(full)) begin
            bytes_left = 16'(full);
            zlp_armed  = ((32'(full) & (packet_bytes() - 1)) == 0);
        end else begin
            bytes_left = wlen;
            zlp_armed  = 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the responses caused by one accepted request
    function automatic void predict_request(t_req q);
        t_rsp       chunk_rsps[$];
        t_rsp       r;
        logic [1:0] cls;
        cls = q.request_type[6:5];
        if (q.action == ACT_IN_COMPLETE) begin
            if (next_chunk(r)) chunk_rsps.push_back(r);
        end else if (q.request_type[7] == DIR_IN) begin
            if (cls == CLASS_STANDARD && q.request_code == REQ_GET_DESCRIPTOR) begin
                if (open_descriptor(q.request_value, q.request_length)) begin
                    if (next_chunk(r)) chunk_rsps.push_back(r);
                end
            end
        end else if (cls == CLASS_STANDARD && q.request_code == REQ_SET_ADDRESS) begin
            chunk_rsps.push_back(make_rsp(KIND_SET_ADDR, '0, '0, '0,
                                          q.request_value[6:0], 1'b0));
            bytes_left = '0;
            zlp_armed  = 1'b1;
            if (next_chunk(r)) chunk_rsps.push_back(r);
        end else if (cls == CLASS_STANDARD && q.request_code == REQ_SET_CONFIGURATION) begin
            config_value = q.request_value[7:0];
            chunk_rsps.push_back(make_rsp(KIND_EP_ENABLE, '0, '0, '0, '0,
                                          config_value != 0));
            bytes_left = '0;
            zlp_armed  = 1'b1;
            if (next_chunk(r)) chunk_rsps.push_back(r);
        end else if (cls == CLASS_CLASS && q.request_code == REQ_SET_IDLE) begin
            bytes_left = '0;
            zlp_armed  = 1'b1;
            if (next_chunk(r)) chunk_rsps.push_back(r);
        end
        if (chunk_rsps.size() > 0) chunk_rsps[chunk_rsps.size() - 1].last = 1'b1;
        foreach (chunk_rsps[k]) expected_rsps.push_back(chunk_rsps[k]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request and response handshakes
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Request driver: one item at a time from pending_reqs
    always @(negedge i_clk) begin
        logic next_valid;
        t_req next_req;
        next_valid = i_valid;
        next_req   = i_req;
        if (i_valid && req_fire) next_valid = 1'b0;
        if (i_rst_n && !next_valid) begin
            if (req_gap > 0) begin
                req_gap--;
            end else if (pending_reqs.size() > 0) begin
                next_req   = pending_reqs.pop_front();
                next_valid = 1'b1;
                req_gap    = pick_gap();
            end
        end
        i_valid <= next_valid;
        i_req   <= next_req;
    end

    // Response back-pressure
    always @(negedge i_clk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (rsp_stall == 0 && $urandom_range(0, 5) == 0) rsp_stall = pick_gap();
        if (rsp_stall > 0) begin
            ready_next = 1'b0;
            rsp_stall--;
        end
        i_ready <= ready_next;
    end

    // Monitor: predict on request, compare on response
    always @(posedge i_clk) begin
        t_rsp want;
        req_fire <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_request(i_req);
            if (o_valid && i_ready) begin
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t ns: response mismatch: expected none, actual %h",
                             $time, o_rsp);
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("kind", want.kind, o_rsp.kind);
                    check_field("descriptor_id", want.descriptor_id, o_rsp.descriptor_id);
                    check_field("byte_offset", want.byte_offset, o_rsp.byte_offset);
                    check_field("packet_length", want.packet_length, o_rsp.packet_length);
                    check_field("device_address", want.device_address,
                                o_rsp.device_address);
                    check_field("endpoints_on", want.endpoints_on, o_rsp.endpoints_on);
                    check_field("last", want.last, o_rsp.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    // Write one register, then read it back
    task automatic reg_access(logic [1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        case (idx)
            CFG_MAX_PACKET_SHIFT: begin
                cfg_shift = value[2:0];
                mask      = 32'h7;
            end
            CFG_DEVICE_DESC_LENGTH: begin
                cfg_device_len = value[7:0];
                mask           = 32'hFF;
            end
            CFG_CONFIG_TOTAL_LENGTH: begin
                cfg_config_len = value[9:0];
                mask           = 32'h3FF;
            end
            default: begin
                cfg_langid_len = value[7:0];
                mask           = 32'hFF;
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== (value & mask)) begin
            errors++;
            $display("%0t ns: register %0d readback mismatch: expected %0d, actual %0d",
                     $time, idx, value & mask, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(logic [2:0] shift, logic [7:0] dev_len,
                                logic [9:0] cfg_len, logic [7:0] lang_len);
        reg_access(CFG_MAX_PACKET_SHIFT, 32'(shift));
        reg_access(CFG_DEVICE_DESC_LENGTH, 32'(dev_len));
        reg_access(CFG_CONFIG_TOTAL_LENGTH, 32'(cfg_len));
        reg_access(CFG_LANGID_LENGTH, 32'(lang_len));
    endtask

    // Block until every request is taken and every response is back;
    // checked at the rising edge, where the driver's queue and valid agree
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_req mk_setup(logic [7:0] rtype, logic [7:0] code,
                                      logic [15:0] value, logic [15:0] wlen);
        t_req q;
        q.action         = ACT_SETUP;
        q.request_type   = rtype;
        q.request_code   = code;
        q.request_value  = value;
        q.request_length = wlen;
        return q;
    endfunction

    // IN-complete; the setup fields carry junk
    function automatic t_req mk_in();
        t_req q;
        q        = 49'({$urandom, $urandom});
        q.action = ACT_IN_COMPLETE;
        return q;
    endfunction

    function automatic logic [7:0] req_type(logic dir, logic [1:0] cls);
        return {dir, cls, 5'($urandom)};
    endfunction

    function automatic logic [15:0] rand_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return 16'($urandom_range(0, 80));
        if (roll < 55) return 16'hFFFF;
        if (roll < 75) return 16'($urandom_range(0, 1100));
        if (roll < 85) return 16'($urandom_range(1, 16) * 8);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_desc_value();
        logic [7:0] dtype;
        logic [7:0] idx;
        case ($urandom_range(0, 9))
            0, 1:    dtype = DT_DEVICE;
            2, 3:    dtype = DT_CONFIG;
            4, 5, 6: dtype = DT_STRING;
            7:       dtype = DT_REPORT;
            default: dtype = 8'($urandom);
        endcase
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        return {dtype, idx};
    endfunction

    // Queue one request sequence; returns the number of requests queued
    function automatic int unsigned add_sequence();
        int unsigned roll;
        int unsigned n_in;
        int unsigned count;
        t_req        q;
        roll  = $urandom_range(0, 99);
        count = 1;
        if (roll < 55) begin
            // descriptor read followed by its IN stages, sometimes cut short
            pending_reqs.push_back(mk_setup(req_type(DIR_IN, CLASS_STANDARD),
                                            REQ_GET_DESCRIPTOR, rand_desc_value(),
                                            rand_length()));
            roll = $urandom_range(0, 99);
            if (roll < 80) n_in = $urandom_range(1, 9);
            else if (roll < 95) n_in = 0;
            else n_in = $urandom_range(10, 130);
            repeat (n_in) pending_reqs.push_back(mk_in());
            count += n_in;
        end else if (roll < 65) begin
            pending_reqs.push_back(mk_setup(req_type(DIR_OUT, CLASS_STANDARD),
                                            REQ_SET_ADDRESS, 16'($urandom), rand_length()));
            if ($urandom_range(0, 1) == 0) begin
                pending_reqs.push_back(mk_in());
                count++;
            end
        end else if (roll < 75) begin
            pending_reqs.push_back(mk_setup(req_type(DIR_OUT, CLASS_STANDARD),
                                            REQ_SET_CONFIGURATION,
                                            ($urandom_range(0, 1) == 0) ?
                                                {8'($urandom), 8'h00} : 16'($urandom),
                                            rand_length()));
        end else if (roll < 82) begin
            pending_reqs.push_back(mk_setup(req_type(DIR_OUT, CLASS_CLASS), REQ_SET_IDLE,
                                            16'($urandom), rand_length()));
        end else if (roll < 88) begin
            // near misses: random type byte with a low request code
            pending_reqs.push_back(mk_setup(8'($urandom), 8'($urandom_range(0, 15)),
                                            rand_desc_value(), rand_length()));
        end else begin
            q = 49'({$urandom, $urandom});
            pending_reqs.push_back(q);
        end
        return count;
    endfunction

    initial begin
        int unsigned added;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at reset defaults (16-byte packets)
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_DEVICE, 8'h00}, 16'hFFFF));
        pending_reqs.push_back(mk_in());
        pending_reqs.push_back(mk_in());
        // config read dropped by a new device read
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_CONFIG, 8'hFF}, 16'hFFFF));
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_DEVICE, 8'h00}, 16'd4));
        pending_reqs.push_back(mk_in());
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_STRING, STR_LANGID}, 16'd2));
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_STRING, STR_MAKER}, 16'd18));
        pending_reqs.push_back(mk_in());
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_STRING, STR_PRODUCT}, 16'd0));
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_STRING, STR_SERIAL}, 16'hFFFF));
        pending_reqs.push_back(mk_in());
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_REPORT, 8'h00}, 16'd45));
        pending_reqs.push_back(mk_in());
        pending_reqs.push_back(mk_in());
        // unknown string index and type leave state alone
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_STRING, STR_UNKNOWN}, 16'hFFFF));
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_UNKNOWN, 8'h00}, 16'hFFFF));
        pending_reqs.push_back(mk_in());
        // address wider than seven bits
        pending_reqs.push_back(mk_setup({DIR_OUT, CLASS_STANDARD, 5'd0}, REQ_SET_ADDRESS,
                                        16'hFFFF, 16'h0000));
        pending_reqs.push_back(mk_setup({DIR_OUT, CLASS_STANDARD, 5'd0},
                                        REQ_SET_CONFIGURATION, 16'h0001, 16'h0000));
        pending_reqs.push_back(mk_setup({DIR_OUT, CLASS_STANDARD, 5'd0},
                                        REQ_SET_CONFIGURATION, 16'hFF00, 16'hFFFF));
        pending_reqs.push_back(mk_setup({DIR_OUT, CLASS_CLASS, 5'd0}, REQ_SET_IDLE,
                                        16'h0000, 16'h0000));
        // wrong class, wrong direction, unknown code
        pending_reqs.push_back(mk_setup({DIR_IN, CLASS_CLASS, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_DEVICE, 8'h00}, 16'hFFFF));
        pending_reqs.push_back(mk_setup({DIR_OUT, CLASS_STANDARD, 5'd0}, REQ_GET_DESCRIPTOR,
                                        {DT_DEVICE, 8'h00}, 16'hFFFF));
        pending_reqs.push_back(mk_setup(8'hFF, REQ_UNKNOWN, 16'hFFFF, 16'hFFFF));
        wait_idle();

        // Random sequences under a series of register settings
        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            idle_on = (phase % 3 != 0);
            case (phase)
                1:       apply_config(3'd3, 8'd0, 10'd0, 8'd0);
                2:       apply_config(3'd6, 8'd255, 10'd1023, 8'd255);
                3:       apply_config(3'd0, 8'd64, 10'd512, 8'd32);
                4:       apply_config(3'd7, 8'd64, 10'd128, 8'd128);
                default: apply_config(3'($urandom), 8'($urandom), 10'($urandom),
                                      8'($urandom));
            endcase
            added = 0;
            while (added < REQS_PER_PHASE) added += add_sequence();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_rsps.size() != 0) begin
            errors++;
            $display("%0t ns: responses missing: expected %0d more, actual 0",
                     $time, expected_rsps.size());
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/usbep_pkg.sv
hdl/usbep_out_fifo.sv
hdl/usb_control_endpoint_responder.sv
tb/sv/testbench.sv
